// ----- sv/pps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and codes shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Table size and derived widths
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths
  localparam int ACT_W  = 2;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One task table entry
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic tick;
    logic clear;
    logic rd_en;
    idx_t rd_addr;
    logic cmp_en;
    logic update;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic all_done;
    logic out_free;
  } status_t;

  // Result payload
  typedef struct packed {
    logic [SLOT_W-1:0] run_slot;
    logic              idle;
    logic [TIME_W-1:0] tick_time;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_RES
  } state_e;

endpackage

// ----- sv/pps_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_in_if
// Command channel: load, tick and clear transactions.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::ACT_W-1:0]    action;
  logic [pps_pkg::SLOT_W-1:0]   slot;
  logic [pps_pkg::TIME_W-1:0]   arrival;
  logic [pps_pkg::TIME_W-1:0]   burst;
  logic [pps_pkg::PRIO_W-1:0]   prio;

  modport source (output valid, action, slot, arrival, burst, prio, input ready);
  modport sink   (input valid, action, slot, arrival, burst, prio, output ready);
endinterface

// ----- sv/pps_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: one transaction per tick.
// ----------------------------------------------------------------------------
interface pps_out_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::SLOT_W-1:0]   run_slot;
  logic                         idle;
  logic [pps_pkg::TIME_W-1:0]   tick_time;
  logic                         finished;
  logic [pps_pkg::TIME_W-1:0]   finish_time;
  logic [pps_pkg::TIME_W-1:0]   turnaround;
  logic [pps_pkg::TIME_W-1:0]   waiting;
  logic                         all_done;

  modport source (output valid, run_slot, idle, tick_time, finished, finish_time,
                  turnaround, waiting, all_done, input ready);
  modport sink   (input valid, run_slot, idle, tick_time, finished, finish_time,
                  turnaround, waiting, all_done, output ready);
endinterface

// ----- sv/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Priority scheduler over a table of task slots, one time unit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries load, tick and clear transactions; out_o carries one result
//   transaction per tick and none for load, clear or the unused action code.
//   Load and clear are applied as they are accepted. For a tick the table
//   memory has one read port and the scan reads one slot per cycle, then an
//   update state updates the winner and a result state loads the result
//   register. A tick that finds every loaded task done skips the scan and
//   the update and goes straight to loading the result register.
//   Results leave through an output register, so the next command is taken
//   while a result still waits. If the receiver stalls, a following tick
//   finishes its scan and then holds in place until the register frees up.
//   After reset the table is empty, time is zero and no result is pending;
//   no memory clearing pass is needed since per-slot valid flags are reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input logic     clk_i,
  input logic     rst_ni,
  pps_in_if.sink  in_i,
  pps_out_if.source out_o
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;
  pps_pkg::out_t    res;
  logic             res_valid;
  logic             in_ready;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  pps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (in_i.slot),
    .arrival_i   (in_i.arrival),
    .burst_i     (in_i.burst),
    .prio_i      (in_i.prio),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (res_valid),
    .out_o       (res)
  );

  // Channel wiring
  assign in_i.ready        = in_ready;
  assign out_o.valid       = res_valid;
  assign out_o.run_slot    = res.run_slot;
  assign out_o.idle        = res.idle;
  assign out_o.tick_time   = res.tick_time;
  assign out_o.finished    = res.finished;
  assign out_o.finish_time = res.finish_time;
  assign out_o.turnaround  = res.turnaround;
  assign out_o.waiting     = res.waiting;
  assign out_o.all_done    = res.all_done;

endmodule

// ----- sv/pps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: accepts commands; for a tick it walks the task table and updates
// the winner, or skips both when every loaded task is done, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [pps_pkg::ACT_W-1:0] action_i,
  input  pps_pkg::status_t          status_i,
  output logic                      in_ready_o,
  output pps_pkg::cmd_t             cmd_o
);

  pps_pkg::state_e state_q, state_d;
  pps_pkg::cnt_t   cnt_q, cnt_d;

  // State and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = cnt_q[pps_pkg::IDX_W-1:0];
    case (state_q)
      pps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          case (action_i)
            pps_pkg::ACT_LOAD: begin
              cmd_o.load = 1'b1;
            end
            pps_pkg::ACT_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = status_i.all_done ? pps_pkg::ST_RES : pps_pkg::ST_SCAN;
            end
            pps_pkg::ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pps_pkg::ST_SCAN: begin
        // read slot cnt, compare the slot read in the previous cycle
        cmd_o.rd_en  = (cnt_q != pps_pkg::cnt_t'(pps_pkg::MAX_TASKS));
        cmd_o.cmp_en = (cnt_q != '0);
        cnt_d        = cnt_q + pps_pkg::cnt_t'(1);
        if (cnt_q == pps_pkg::cnt_t'(pps_pkg::MAX_TASKS)) begin
          state_d = pps_pkg::ST_UPD;
        end
      end
      pps_pkg::ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = pps_pkg::ST_RES;
      end
      pps_pkg::ST_RES: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/pps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: task table memory, valid and done flags, counters, time,
// best-candidate registers and the output register.
// ----------------------------------------------------------------------------
module pps_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pps_pkg::SLOT_W-1:0] slot_i,
  input  logic [pps_pkg::TIME_W-1:0] arrival_i,
  input  logic [pps_pkg::TIME_W-1:0] burst_i,
  input  logic [pps_pkg::PRIO_W-1:0] prio_i,
  input  pps_pkg::cmd_t              cmd_i,
  input  logic                       out_ready_i,
  output pps_pkg::status_t           status_o,
  output logic                       out_valid_o,
  output pps_pkg::out_t              out_o
);

  // Task table, no reset: only valid slots are ever used
  pps_pkg::entry_t mem [pps_pkg::MAX_TASKS];

  logic [pps_pkg::MAX_TASKS-1:0] valid_q;
  logic [pps_pkg::MAX_TASKS-1:0] done_q;
  pps_pkg::cnt_t                 loaded_q;
  pps_pkg::cnt_t                 done_cnt_q;
  logic [pps_pkg::TIME_W-1:0]    time_q;
  logic                          found_q;
  logic                          out_valid_q;

  pps_pkg::idx_t                 rd_idx_q;
  pps_pkg::entry_t               rd_q;
  pps_pkg::idx_t                 best_idx_q;
  pps_pkg::entry_t               best_q;
  logic [pps_pkg::TIME_W-1:0]    tick_time_q;
  logic                          all_done_q;
  logic                          finished_q;
  logic [pps_pkg::TIME_W-1:0]    fin_q;
  logic [pps_pkg::TIME_W-1:0]    tat_q;
  pps_pkg::out_t                 out_q;

  logic                          load_ok;
  pps_pkg::idx_t                 load_idx;
  logic                          upd_run;
  logic                          mem_we;
  pps_pkg::idx_t                 mem_waddr;
  pps_pkg::entry_t               mem_wdata;
  pps_pkg::entry_t               dec_entry;
  logic [pps_pkg::TIME_W-1:0]    time_next;
  logic                          elig;
  logic                          better;
  logic                          last_unit;
  pps_pkg::out_t                 res;

  // Load qualification and write port select
  always_comb begin
    load_ok   = cmd_i.load && (burst_i != '0) && (32'(slot_i) < pps_pkg::MAX_TASKS);
    load_idx  = pps_pkg::idx_t'(slot_i);
    upd_run   = cmd_i.update && found_q;
    dec_entry = best_q;
    dec_entry.remaining = best_q.remaining - 16'd1;
    last_unit = (best_q.remaining == 16'd1);
    mem_we    = load_ok || upd_run;
    mem_waddr = load_ok ? load_idx : best_idx_q;
    mem_wdata = load_ok ? {arrival_i, burst_i, burst_i, prio_i} : dec_entry;
    time_next = (time_q == pps_pkg::TIME_MAX) ? time_q : time_q + 16'd1;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem[cmd_i.rd_addr];
      rd_idx_q <= cmd_i.rd_addr;
    end
  end

  // Candidate compare: strict compares keep the lower slot on full ties
  always_comb begin
    elig   = valid_q[rd_idx_q] && !done_q[rd_idx_q] && (rd_q.arrival <= time_q);
    better = !found_q || (rd_q.prio < best_q.prio) ||
             ((rd_q.prio == best_q.prio) && (rd_q.arrival < best_q.arrival));
  end

  // Control state: flags, counters, time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      done_q      <= '0;
      loaded_q    <= '0;
      done_cnt_q  <= '0;
      time_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        valid_q    <= '0;
        done_q     <= '0;
        loaded_q   <= '0;
        done_cnt_q <= '0;
        time_q     <= '0;
      end
      if (load_ok) begin
        valid_q[load_idx] <= 1'b1;
        done_q[load_idx]  <= 1'b0;
        if (!valid_q[load_idx]) begin
          loaded_q <= loaded_q + pps_pkg::cnt_t'(1);
        end else if (done_q[load_idx] && (done_cnt_q != '0)) begin
          done_cnt_q <= done_cnt_q - pps_pkg::cnt_t'(1);
        end
      end
      if (cmd_i.tick) begin
        found_q <= 1'b0;
      end
      if (cmd_i.cmp_en && elig && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.update) begin
        time_q <= time_next;
        if (upd_run && last_unit) begin
          done_q[best_idx_q] <= 1'b1;
          done_cnt_q         <= done_cnt_q + pps_pkg::cnt_t'(1);
        end
      end
      // output register handshake
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      tick_time_q <= time_q;
      all_done_q  <= (done_cnt_q >= loaded_q);
    end
    if (cmd_i.cmp_en && elig && better) begin
      best_idx_q <= rd_idx_q;
      best_q     <= rd_q;
    end
    if (cmd_i.update) begin
      finished_q <= found_q && last_unit;
      fin_q      <= time_next;
      tat_q      <= time_next - best_q.arrival;
    end
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  // Result assembly
  always_comb begin
    res           = '0;
    res.tick_time = tick_time_q;
    if (all_done_q) begin
      res.idle     = 1'b1;
      res.all_done = 1'b1;
    end else if (!found_q) begin
      res.idle = 1'b1;
    end else begin
      res.run_slot = pps_pkg::SLOT_W'(best_idx_q);
      if (finished_q) begin
        res.finished    = 1'b1;
        res.finish_time = fin_q;
        res.turnaround  = tat_q;
        res.waiting     = (tat_q > best_q.burst) ? tat_q - best_q.burst : '0;
      end
    end
  end

  assign status_o.all_done = (done_cnt_q >= loaded_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;

  // Bookkeeping invariants
  a_loaded_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(loaded_q) == $countones(valid_q))
    else $error("loaded count differs from valid slots");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(done_cnt_q) == $countones(done_q))
    else $error("done count differs from done slots");

  a_done_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~valid_q) == '0)
    else $error("done flag on an empty slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

endmodule
